[design/qce_pkg.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator package
// Shared widths, command codes, term multiplier table and arithmetic helpers.
// ----------------------------------------------------------------------------
package qce_pkg;

    localparam int COEFF_WIDTH     = 32;
    localparam int PARAM_FRAC_BITS = 15;

    localparam int NUM_COEFFS  = 6;
    localparam int NUM_POWERS  = NUM_COEFFS - 1;
    localparam int NUM_CMDS    = 4;
    localparam int CFG_IDX_W   = $clog2(NUM_COEFFS);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_HALF_W  = CFG_DATA_W / 2;
    localparam int CMD_W       = 2;
    localparam int PARAM_W     = 16;
    localparam int OUT_W       = 48;

    localparam int POW_CAP_LOG = 24;
    localparam int POW_W       = POW_CAP_LOG + 1;
    localparam int POW_PROD_W  = POW_W + PARAM_W;

    localparam int PROD_W      = COEFF_WIDTH + POW_W + 1;
    localparam int TERM_W      = PROD_W - PARAM_FRAC_BITS;
    localparam int MULT_W      = 6;
    localparam int SCALED_W    = TERM_W + MULT_W;
    localparam int ACC_RAW     = SCALED_W + 3;
    localparam int ACC_W       = (ACC_RAW > OUT_W) ? ACC_RAW : OUT_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_POS  = 2'd0,
        CMD_D1   = 2'd1,
        CMD_D2   = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef logic        [POW_W-1:0]       pow_t;
    typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
    typedef logic signed [TERM_W-1:0]      term_t;
    typedef logic signed [SCALED_W-1:0]    scaled_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic signed [OUT_W-1:0]       out_t;

    localparam pow_t POW_CAP = pow_t'(1) << POW_CAP_LOG;
    localparam out_t OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam out_t OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // Row per command, column per term slot; slot 0 is the unshifted constant term.
    localparam logic [MULT_W-1:0] MULT_TABLE [NUM_CMDS][NUM_COEFFS] = '{
        '{6'd1, 6'd1, 6'd1,  6'd1,  6'd1, 6'd1},
        '{6'd1, 6'd2, 6'd3,  6'd4,  6'd5, 6'd0},
        '{6'd2, 6'd6, 6'd12, 6'd20, 6'd0, 6'd0},
        '{6'd0, 6'd0, 6'd0,  6'd0,  6'd0, 6'd0}
    };

    typedef struct packed {
        logic en_term;
        logic en_scale;
        logic en_pair;
        logic en_sum;
        cmd_t cmd_term;
        cmd_t cmd_scale;
    } lane_ctl_t;

    typedef struct packed {
        pow_t pw;
        logic ovf;
    } pow_res_t;

    typedef struct packed {
        out_t value;
        logic clipped;
    } clip_res_t;

    function automatic pow_res_t pow_step(pow_t p, logic [PARAM_W-1:0] t);
        logic [POW_PROD_W-1:0] prod;
        logic [POW_PROD_W-1:0] shifted;
        pow_res_t              res;
        prod    = POW_PROD_W'(p) * POW_PROD_W'(t);
        shifted = prod >> PARAM_FRAC_BITS;
        if (shifted > POW_PROD_W'(POW_CAP))
        begin
            res.pw  = POW_CAP;
            res.ovf = 1'b1;
        end
        else
        begin
            res.pw  = pow_t'(shifted);
            res.ovf = 1'b0;
        end
        return res;
    endfunction

    function automatic clip_res_t clip_out(acc_t v);
        clip_res_t res;
        if (v > ACC_W'(OUT_MAX))
        begin
            res.value   = OUT_MAX;
            res.clipped = 1'b1;
        end
        else if (v < ACC_W'(OUT_MIN))
        begin
            res.value   = OUT_MIN;
            res.clipped = 1'b1;
        end
        else
        begin
            res.value   = OUT_W'(v);
            res.clipped = 1'b0;
        end
        return res;
    endfunction

endpackage

[design/qce_item_if.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator input channel
// Valid/ready channel carrying the command and the curve parameter.
// ----------------------------------------------------------------------------
interface qce_item_if;
    import qce_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [PARAM_W-1:0] param_t;

    modport source (output valid, output cmd, output param_t, input ready);
    modport sink   (input valid, input cmd, input param_t, output ready);
endinterface

[design/qce_result_if.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator result channel
// Valid/ready channel carrying the x and y values and the saturation flag.
// ----------------------------------------------------------------------------
interface qce_result_if;
    import qce_pkg::*;

    logic       valid;
    logic       ready;
    out_t       x_value;
    out_t       y_value;
    logic       saturated;

    modport source (output valid, output x_value, output y_value, output saturated,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input saturated,
                    output ready);
endinterface

[design/qce_cfg_if.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface qce_cfg_if;
    import qce_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/quintic_curve_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator
// One transfer per cycle is sustained while the result channel is ready;
// each of the 9 stages holds while the stage after it is full and stalled,
// so bubbles are squeezed out.
// Reset clears all coefficient registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module quintic_curve_evaluator_unit (
    input  logic clk,
    input  logic rst_n,
    qce_item_if.sink     item,
    qce_result_if.source result,
    qce_cfg_if.sink      cfg
);
    import qce_pkg::*;

    localparam int POW_STAGES  = NUM_POWERS - 1;
    localparam int TERM_STAGE  = POW_STAGES;
    localparam int SCALE_STAGE = TERM_STAGE + 1;
    localparam int PAIR_STAGE  = SCALE_STAGE + 1;
    localparam int SUM_STAGE   = PAIR_STAGE + 1;
    localparam int OUT_STAGE   = SUM_STAGE + 1;
    localparam int NUM_STAGES  = OUT_STAGE + 1;

    logic [CFG_DATA_W-1:0] coeff_reg [NUM_COEFFS];
    coeff_t                coeff_x   [NUM_COEFFS];
    coeff_t                coeff_y   [NUM_COEFFS];

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;
    cmd_t                  cmd_reg   [NUM_STAGES];
    logic [OUT_STAGE-1:0]  pow_sat_reg;
    logic [OUT_STAGE-1:0]  pow_sat_next;

    pow_t                  pw_next   [POW_STAGES][NUM_POWERS];
    pow_t                  pw_reg    [POW_STAGES][NUM_POWERS];
    pow_res_t              step      [POW_STAGES];

    lane_ctl_t             lane_ctl;
    acc_t                  x_sum;
    acc_t                  y_sum;
    clip_res_t             clip_x;
    clip_res_t             clip_y;
    out_t                  x_value_reg;
    out_t                  y_value_reg;
    logic                  saturated_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEFFS; k++)
            begin
                coeff_reg[k] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(NUM_COEFFS))
        begin
            coeff_reg[cfg.index] <= cfg.data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_COEFFS; k++)
        begin
            coeff_x[k] = coeff_reg[k][CFG_HALF_W +: COEFF_WIDTH];
            coeff_y[k] = coeff_reg[k][0 +: COEFF_WIDTH];
        end
    end

    always_comb
    begin
        en[NUM_STAGES - 1] = !v_reg[NUM_STAGES - 1] || result.ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end

    assign item.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= item.valid;
            end
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s - 1];
                end
            end
        end
    end

    // Power stage s adds t to the power of s + 2; slot 0 carries t itself.
    always_comb
    begin
        for (int p = 0; p < NUM_POWERS; p++)
        begin
            pw_next[0][p] = '0;
        end
        pw_next[0][0] = pow_t'(item.param_t);
        for (int s = 1; s < POW_STAGES; s++)
        begin
            for (int p = 0; p < NUM_POWERS; p++)
            begin
                pw_next[s][p] = pw_reg[s - 1][p];
            end
        end
        for (int s = 0; s < POW_STAGES; s++)
        begin
            step[s]           = pow_step(pw_next[s][s], PARAM_W'(pw_next[s][0]));
            pw_next[s][s + 1] = step[s].pw;
        end
        pow_sat_next[0] = step[0].ovf;
        for (int s = 1; s < POW_STAGES; s++)
        begin
            pow_sat_next[s] = pow_sat_reg[s - 1] | step[s].ovf;
        end
        for (int s = POW_STAGES; s < OUT_STAGE; s++)
        begin
            pow_sat_next[s] = pow_sat_reg[s - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < POW_STAGES; s++)
        begin
            if (en[s])
            begin
                for (int p = 0; p < NUM_POWERS; p++)
                begin
                    pw_reg[s][p] <= pw_next[s][p];
                end
            end
        end
        if (en[0])
        begin
            cmd_reg[0] <= cmd_t'(item.cmd);
        end
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            if (en[s])
            begin
                cmd_reg[s] <= cmd_reg[s - 1];
            end
        end
        for (int s = 0; s < OUT_STAGE; s++)
        begin
            if (en[s])
            begin
                pow_sat_reg[s] <= pow_sat_next[s];
            end
        end
    end

    always_comb
    begin
        lane_ctl.en_term   = en[TERM_STAGE];
        lane_ctl.en_scale  = en[SCALE_STAGE];
        lane_ctl.en_pair   = en[PAIR_STAGE];
        lane_ctl.en_sum    = en[SUM_STAGE];
        lane_ctl.cmd_term  = cmd_reg[TERM_STAGE - 1];
        lane_ctl.cmd_scale = cmd_reg[SCALE_STAGE - 1];
    end

    qce_poly_lane u_lane_x (
        .clk   (clk),
        .ctl   (lane_ctl),
        .pw    (pw_reg[POW_STAGES - 1]),
        .coeff (coeff_x),
        .sum   (x_sum)
    );

    qce_poly_lane u_lane_y (
        .clk   (clk),
        .ctl   (lane_ctl),
        .pw    (pw_reg[POW_STAGES - 1]),
        .coeff (coeff_y),
        .sum   (y_sum)
    );

    assign clip_x = clip_out(x_sum);
    assign clip_y = clip_out(y_sum);

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            if (cmd_reg[SUM_STAGE] == CMD_NONE)
            begin
                x_value_reg   <= '0;
                y_value_reg   <= '0;
                saturated_reg <= 1'b0;
            end
            else
            begin
                x_value_reg   <= clip_x.value;
                y_value_reg   <= clip_y.value;
                saturated_reg <= pow_sat_reg[SUM_STAGE] | clip_x.clipped | clip_y.clipped;
            end
        end
    end

    assign result.valid     = v_reg[OUT_STAGE];
    assign result.x_value   = x_value_reg;
    assign result.y_value   = y_value_reg;
    assign result.saturated = saturated_reg;

    a_blocked_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> &v_reg)
        else $error("Input refused while the pipeline still has an empty stage.");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> v_reg[0])
        else $error("Accepted input transfer did not reach the first stage.");

    a_sum_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[SUM_STAGE] && !en[SUM_STAGE]
        |=> v_reg[SUM_STAGE] && $stable(x_sum) && $stable(y_sum))
        else $error("Stalled sum stage lost or changed its contents.");

    a_unused_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && cmd_reg[OUT_STAGE] == CMD_NONE
        |-> result.x_value == '0 && result.y_value == '0 && !result.saturated)
        else $error("Unused command produced a nonzero result.");

endmodule

[design/qce_poly_lane.sv]
// ----------------------------------------------------------------------------
// Quintic curve evaluator polynomial lane
// Four-stage term pipeline for one curve component: coefficient products,
// derivative scaling, pairwise adds and the final sum.
// ----------------------------------------------------------------------------
module qce_poly_lane (
    input  logic               clk,
    input  qce_pkg::lane_ctl_t ctl,
    input  qce_pkg::pow_t      pw    [qce_pkg::NUM_POWERS],
    input  qce_pkg::coeff_t    coeff [qce_pkg::NUM_COEFFS],
    output qce_pkg::acc_t      sum
);
    import qce_pkg::*;

    localparam int NUM_PAIRS = NUM_COEFFS / 2;

    coeff_t                   sel         [NUM_COEFFS];
    logic signed [PROD_W-1:0] prod        [NUM_POWERS];
    coeff_t                   const_reg;
    term_t                    term_reg    [NUM_POWERS];
    scaled_t                  scaled_next [NUM_COEFFS];
    scaled_t                  scaled_reg  [NUM_COEFFS];
    acc_t                     pair_reg    [NUM_PAIRS];
    acc_t                     sum_next;
    acc_t                     sum_reg;

    // Slot k of the selected command takes the coefficient of degree k plus the
    // derivative order; slots past degree five are zero.
    always_comb
    begin
        for (int k = 0; k < NUM_COEFFS; k++)
        begin
            sel[k] = '0;
        end
        unique case (ctl.cmd_term)
            CMD_D1:
            begin
                for (int k = 0; k < NUM_COEFFS - 1; k++)
                begin
                    sel[k] = coeff[k + 1];
                end
            end
            CMD_D2:
            begin
                for (int k = 0; k < NUM_COEFFS - 2; k++)
                begin
                    sel[k] = coeff[k + 2];
                end
            end
            default:
            begin
                for (int k = 0; k < NUM_COEFFS; k++)
                begin
                    sel[k] = coeff[k];
                end
            end
        endcase
        for (int j = 0; j < NUM_POWERS; j++)
        begin
            prod[j] = PROD_W'(sel[j + 1]) * signed'(PROD_W'(pw[j]));
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_COEFFS; j++)
        begin
            scaled_next[j] = '0;
        end
        scaled_next[0] = SCALED_W'(const_reg)
                       * signed'(SCALED_W'(MULT_TABLE[ctl.cmd_scale][0]));
        for (int j = 0; j < NUM_POWERS; j++)
        begin
            scaled_next[j + 1] = SCALED_W'(term_reg[j])
                               * signed'(SCALED_W'(MULT_TABLE[ctl.cmd_scale][j + 1]));
        end
        sum_next = '0;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            sum_next = sum_next + pair_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_term)
        begin
            const_reg <= sel[0];
            for (int j = 0; j < NUM_POWERS; j++)
            begin
                term_reg[j] <= TERM_W'(prod[j] >>> PARAM_FRAC_BITS);
            end
        end
        if (ctl.en_scale)
        begin
            for (int j = 0; j < NUM_COEFFS; j++)
            begin
                scaled_reg[j] <= scaled_next[j];
            end
        end
        if (ctl.en_pair)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                pair_reg[i] <= ACC_W'(scaled_reg[2 * i]) + ACC_W'(scaled_reg[2 * i + 1]);
            end
        end
        if (ctl.en_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
